// ===== rtl/core/rmmd_pkg.sv =====
// Shared types and constants for the register-mapped multiply/divide unit.
package rmmd_pkg;

    localparam int OFS_W         = 3;
    localparam int BYTE_W        = 8;
    localparam int WORD_W        = 16;
    localparam int OPERAND_COUNT = 6;
    localparam int STEP_W        = 4;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [OFS_W-1:0] OFS_MUL_START = 3'd1;
    localparam logic [OFS_W-1:0] OFS_DIV_START = 3'd5;
    localparam logic [OFS_W-1:0] OFS_LIMIT     = 3'd6;

    localparam logic [OFS_W-1:0] OFS_PROD_LO = 3'd0;
    localparam logic [OFS_W-1:0] OFS_PROD_HI = 3'd1;
    localparam logic [OFS_W-1:0] OFS_REM_LO  = 3'd2;
    localparam logic [OFS_W-1:0] OFS_REM_HI  = 3'd3;
    localparam logic [OFS_W-1:0] OFS_QUO_LO  = 3'd4;
    localparam logic [OFS_W-1:0] OFS_QUO_HI  = 3'd5;

    localparam logic [STEP_W-1:0] MUL_LAST = 4'd7;
    localparam logic [STEP_W-1:0] DIV_LAST = 4'd15;

    localparam logic [WORD_W-1:0] DIV_ZERO_QUO = 16'hffff;
    localparam logic [WORD_W-1:0] DIV_ZERO_REM = 16'h0000;

    typedef struct packed {
        logic              start_mul;
        logic              start_div;
        logic [BYTE_W-1:0] mul_a;
        logic [BYTE_W-1:0] mul_b;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } t_arith_ctl;

    typedef struct packed {
        logic              busy;
        logic [WORD_W-1:0] product;
        logic [WORD_W-1:0] quotient;
        logic [WORD_W-1:0] remainder;
    } t_arith_sts;

endpackage

// ===== rtl/core/register_mapped_multiply_divide_top.sv =====
// Register-mapped multiply/divide unit: operand bytes, read mux and request handshake.
// A read request is answered from the output register in the cycle after acceptance, and
// the next request may follow at once unless the output is stalled. A write to offset 1
// starts a shift-add multiply and a write to offset 5 a restoring divide (a zero divisor
// sets the fixed result instead); both step one bit per cycle through the single shared
// adder of the arithmetic unit, and the port stalls until the step count runs out.
module register_mapped_multiply_divide_top import rmmd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_opcode,
    input  logic [OFS_W-1:0]  i_register_offset,
    input  logic [BYTE_W-1:0] i_write_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_read_data
);

    logic [BYTE_W-1:0] r_operand [OPERAND_COUNT];
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_read_data;
    logic [BYTE_W-1:0] n_read_data;

    logic       w_accept;
    logic       w_write;
    t_arith_ctl w_ctl;
    t_arith_sts w_sts;

    assign o_in_stall = w_sts.busy | (r_out_valid & i_out_stall);
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_write    = (i_opcode == OP_WRITE);

    assign w_ctl.start_mul = w_accept & w_write & (i_register_offset == OFS_MUL_START);
    assign w_ctl.start_div = w_accept & w_write & (i_register_offset == OFS_DIV_START);
    assign w_ctl.mul_a     = r_operand[0];
    assign w_ctl.mul_b     = i_write_data;
    assign w_ctl.dividend  = {r_operand[4], i_write_data};
    assign w_ctl.divisor   = {r_operand[2], r_operand[3]};

    rmmd_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts)
    );

    always_comb begin
        unique case (i_register_offset)
            OFS_PROD_LO: n_read_data = w_sts.product[BYTE_W-1:0];
            OFS_PROD_HI: n_read_data = w_sts.product[WORD_W-1:BYTE_W];
            OFS_REM_LO:  n_read_data = w_sts.remainder[BYTE_W-1:0];
            OFS_REM_HI:  n_read_data = w_sts.remainder[WORD_W-1:BYTE_W];
            OFS_QUO_LO:  n_read_data = w_sts.quotient[BYTE_W-1:0];
            OFS_QUO_HI:  n_read_data = w_sts.quotient[WORD_W-1:BYTE_W];
            default:     n_read_data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < OPERAND_COUNT; k++) begin
                r_operand[k] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept && w_write && (i_register_offset < OFS_LIMIT)) begin
                r_operand[i_register_offset] <= i_write_data;
            end
            if (w_accept && !w_write) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !w_write) begin
            r_read_data <= n_read_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;

endmodule

// ===== rtl/core/rmmd_arith.sv =====
// Iterative shift-add multiplier and restoring divider around one shared adder.
module rmmd_arith import rmmd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_arith_ctl i_ctl,
    output t_arith_sts o_sts
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]        r_state;
    logic [STEP_W-1:0] r_count;
    logic [WORD_W-1:0] r_product;
    logic [WORD_W-1:0] r_quotient;
    logic [WORD_W-1:0] r_remainder;
    logic [BYTE_W-1:0] r_mcand;
    logic [WORD_W-1:0] r_divisor;

    logic [WORD_W:0]   w_add_a;
    logic [WORD_W:0]   w_add_b;
    logic              w_sub;
    logic [WORD_W+1:0] w_sum;

    always_comb begin
        unique case (r_state)
            ST_MUL: begin
                w_add_a = {9'b0, r_product[WORD_W-1:BYTE_W]};
                w_add_b = {9'b0, r_mcand & {BYTE_W{r_product[0]}}};
                w_sub   = 1'b0;
            end
            ST_DIV: begin
                w_add_a = {r_remainder, r_quotient[WORD_W-1]};
                w_add_b = {1'b0, r_divisor};
                w_sub   = 1'b1;
            end
            default: begin
                w_add_a = '0;
                w_add_b = '0;
                w_sub   = 1'b0;
            end
        endcase
        w_sum = {1'b0, w_add_a} + ({1'b0, w_add_b} ^ {(WORD_W+2){w_sub}})
              + {{(WORD_W+1){1'b0}}, w_sub};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_product   <= '0;
            r_quotient  <= '0;
            r_remainder <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_count <= '0;
                    if (i_ctl.start_mul) begin
                        r_product <= {{BYTE_W{1'b0}}, i_ctl.mul_b};
                        r_state   <= ST_MUL;
                    end else if (i_ctl.start_div) begin
                        if (i_ctl.divisor == '0) begin
                            r_quotient  <= DIV_ZERO_QUO;
                            r_remainder <= DIV_ZERO_REM;
                        end else begin
                            r_quotient  <= i_ctl.dividend;
                            r_remainder <= '0;
                            r_state     <= ST_DIV;
                        end
                    end
                end
                ST_MUL: begin
                    r_product <= {w_sum[BYTE_W:0], r_product[BYTE_W-1:1]};
                    r_count   <= r_count + 1'b1;
                    if (r_count == MUL_LAST) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_DIV: begin
                    if (w_sum[WORD_W+1]) begin
                        r_remainder <= {r_remainder[WORD_W-2:0], r_quotient[WORD_W-1]};
                        r_quotient  <= {r_quotient[WORD_W-2:0], 1'b0};
                    end else begin
                        r_remainder <= w_sum[WORD_W-1:0];
                        r_quotient  <= {r_quotient[WORD_W-2:0], 1'b1};
                    end
                    r_count <= r_count + 1'b1;
                    if (r_count == DIV_LAST) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_mcand   <= i_ctl.mul_a;
            r_divisor <= i_ctl.divisor;
        end
    end

    assign o_sts.busy      = (r_state != ST_IDLE);
    assign o_sts.product   = r_product;
    assign o_sts.quotient  = r_quotient;
    assign o_sts.remainder = r_remainder;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.start_mul || i_ctl.start_div) |-> r_state == ST_IDLE)
        else $error("start while unit busy");

    a_start_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.start_mul && i_ctl.start_div))
        else $error("multiply and divide started together");

    a_div_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && !i_ctl.start_mul && i_ctl.start_div
         && i_ctl.divisor == '0)
        |=> (r_state == ST_IDLE && r_quotient == DIV_ZERO_QUO
             && r_remainder == DIV_ZERO_REM))
        else $error("zero divisor not handled");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_remainder < r_divisor))
        else $error("partial remainder exceeds divisor");

    a_mul_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL && r_count == MUL_LAST) |=> r_state == ST_IDLE)
        else $error("multiply overran its steps");

endmodule
